// ----- rtl/stream_union_dedup_unit_assert.svh -----
// assertion macros used by the checker file
`ifndef STREAM_UNION_DEDUP_UNIT_ASSERT_SVH
`define STREAM_UNION_DEDUP_UNIT_ASSERT_SVH

// checked only outside reset
`define SUD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked during reset as well
`define SUD_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ----- rtl/sud_pkg.sv -----
`default_nettype none
package sud_pkg;

    // one input item
    typedef struct packed {
        logic signed [31:0] item_value;
        logic               last_of_union;
    } t_in;

    // one result item
    typedef struct packed {
        logic signed [31:0] echo_value;
        logic               is_new;
        logic [7:0]         distinct_count;
        logic               table_overflow;
        logic               union_done;
    } t_out;

    // controller to datapath
    typedef struct packed {
        logic start;
        logic scan;
        logic commit;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic scan_done;
        logic out_free;
    } t_sts;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SCAN   = 3'b010,
        S_COMMIT = 3'b100
    } t_state;

endpackage
`default_nettype wire

// ----- rtl/sud_ctrl.sv -----
`default_nettype none
module sud_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire sud_pkg::t_sts i_sts,
    output sud_pkg::t_cmd      o_cmd
);

    sud_pkg::t_state r_state;
    sud_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sud_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        o_in_stall   = 1'b1;
        case (r_state)
            sud_pkg::S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    n_state     = sud_pkg::S_SCAN;
                end
            end
            sud_pkg::S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_done) begin
                    n_state = sud_pkg::S_COMMIT;
                end
            end
            sud_pkg::S_COMMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = sud_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = sud_pkg::S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ----- rtl/sud_datapath.sv -----
`default_nettype none
module sud_datapath #(
    parameter int TABLE_DEPTH = 128
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire sud_pkg::t_in  i_in,
    input  wire sud_pkg::t_cmd i_cmd,
    output sud_pkg::t_sts      o_sts,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    output sud_pkg::t_out      o_out
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    logic [31:0]   r_mem [TABLE_DEPTH];
    logic [31:0]   r_rdata;
    sud_pkg::t_in  r_item;
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_idx;
    logic          r_pend;
    logic          r_hit;
    logic          r_out_vld;
    sud_pkg::t_out r_out;

    logic          issue;
    logic          full;
    logic          fresh;
    logic          over;
    logic [CW-1:0] n_count;
    logic [CW+7:0] count_ext;

    assign issue     = i_cmd.scan && (r_idx < r_count) && !r_hit;
    assign full      = (r_count == CW'(TABLE_DEPTH));
    assign fresh     = !r_hit && !full;
    assign over      = !r_hit && full;
    assign n_count   = fresh ? r_count + CW'(1) : r_count;
    assign count_ext = {8'd0, n_count};

    assign o_sts.scan_done = r_hit || ((r_idx >= r_count) && !r_pend);
    assign o_sts.out_free  = !r_out_vld || !i_out_stall;
    assign o_out_valid     = r_out_vld;
    assign o_out           = r_out;

    // table: one read port for the scan, one write port for appends
    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_rdata <= r_mem[r_idx[AW-1:0]];
        end
        if (i_cmd.commit && fresh) begin
            r_mem[r_count[AW-1:0]] <= $unsigned(r_item.item_value);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_item <= i_in;
        end
        if (i_cmd.commit) begin
            r_out.echo_value     <= r_item.item_value;
            r_out.is_new         <= fresh;
            r_out.distinct_count <= count_ext[7:0];
            r_out.table_overflow <= over;
            r_out.union_done     <= r_item.last_of_union;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_idx     <= '0;
            r_pend    <= 1'b0;
            r_hit     <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cmd.start) begin
                r_idx  <= '0;
                r_pend <= 1'b0;
                r_hit  <= 1'b0;
            end else if (i_cmd.scan) begin
                r_pend <= issue;
                if (issue) begin
                    r_idx <= r_idx + CW'(1);
                end
                if (r_pend && (r_rdata == $unsigned(r_item.item_value))) begin
                    r_hit <= 1'b1;
                end
            end
            if (i_cmd.commit) begin
                r_count   <= r_item.last_of_union ? '0 : n_count;
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

endmodule
`default_nettype wire

// ----- rtl/stream_union_dedup_unit.sv -----
// channel  direction  handshake                  payload
// in       input      i_in_valid / o_in_stall    i_in  (sud_pkg::t_in)
// out      output     o_out_valid / i_out_stall  o_out (sud_pkg::t_out)
//
// one item at a time: accept, scan, commit; the scan walks the stored entries
// in order and stops early when a match is found
// the scan reads one stored entry per cycle through the single table read port
// synchronous active-low reset clears the count and control only, no table sweep
// the next item is taken while a result waits in the output register
// a stalled output only holds back the commit of the following item
`default_nettype none
module stream_union_dedup_unit #(
    parameter int TABLE_DEPTH = 128
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_in_valid,
    output logic              o_in_stall,
    input  wire sud_pkg::t_in i_in,
    output logic              o_out_valid,
    input  wire logic         i_out_stall,
    output sud_pkg::t_out     o_out
);

    // command and status between the two halves
    sud_pkg::t_cmd cmd;
    sud_pkg::t_sts sts;

    // controller: idle, scan the table, commit the result
    sud_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // datapath: table memory, count, scan index, output register
    sud_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

endmodule
`default_nettype wire

// ----- rtl/sud_checker.sv -----
`default_nettype none
`include "stream_union_dedup_unit_assert.svh"
module sud_checker (
    input wire logic          i_clk,
    input wire logic          i_rst_n,
    input wire logic          i_in_valid,
    input wire logic          i_in_stall,
    input wire logic          i_out_valid,
    input wire logic          i_out_stall,
    input wire sud_pkg::t_out i_out
);

    `SUD_ASSERT(a_out_hold, i_out_valid && i_out_stall |=> i_out_valid, "out valid dropped")
    `SUD_ASSERT(a_out_stable, i_out_valid && i_out_stall |=> $stable(i_out), "out payload moved")
    `SUD_ASSERT(a_one_at_a_time, i_in_valid && !i_in_stall |=> i_in_stall, "second item taken")
    `SUD_ASSERT(a_new_xor_over, i_out_valid |-> !(i_out.is_new && i_out.table_overflow), "new and overflow")

endmodule

bind stream_union_dedup_unit sud_checker u_sud_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_stall  (o_in_stall),
    .i_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .i_out       (o_out)
);
`default_nettype wire
